// File: rtl/core/bas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg
// Types and codes shared by the bump arena slot allocator.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int unsigned SIZE_W  = 29;
    localparam int unsigned VALUE_W = 28;
    localparam int unsigned ID_W    = 3;
    localparam int unsigned CFG_W   = 2;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_MIN_ARENA = 2'd0;
    localparam logic [CFG_W-1:0] CFG_MAX_ARENA = 2'd1;
    localparam logic [CFG_W-1:0] CFG_MAX_ALLOC = 2'd2;

    localparam logic [SIZE_W-1:0] MIN_ARENA_RST = 29'd64;
    localparam logic [SIZE_W-1:0] MAX_ARENA_RST = 29'd268435456;
    localparam logic [SIZE_W-1:0] MAX_ALLOC_RST = 29'd67108864;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_BAD_ID    = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ID_W-1:0]   slot_id;
        logic [SIZE_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic               ok;
        status_t            status;
        logic [VALUE_W-1:0] value;
    } rsp_t;

endpackage

// File: rtl/core/bump_arena_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_arena_slot_allocator
// Arena slot table with create, bump allocate and offset reset requests.
//
//   Port group   Dir  Handshake          Payload
//   s_*          in   s_valid / s_ready  bas_pkg::req_t
//   m_*          out  m_valid / m_ready  bas_pkg::rsp_t
//   cfg_*        in   cfg_wr_en          cfg_index, cfg_wdata
//
// One request per cycle unless results stall; input register, then result register.
// A request is decoded against the slot table in the cycle it leaves the
// input register; the table and the result register update on that edge.
// Only slots 0..7 hold capacity and offset, as slot_id addresses no more.
// Reset clears the live flags and loads the register defaults.
// A stalled result holds the input register; s_ready needs it empty or advancing.
// ----------------------------------------------------------------------------
module bump_arena_slot_allocator #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bas_pkg::req_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bas_pkg::rsp_t                m_data,
    input  logic                         cfg_wr_en,
    input  logic [bas_pkg::CFG_W-1:0]    cfg_index,
    input  logic [bas_pkg::SIZE_W-1:0]   cfg_wdata
);

    localparam int unsigned SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned ADDR_SLOTS = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

    logic [bas_pkg::SIZE_W-1:0] min_arena_reg;
    logic [bas_pkg::SIZE_W-1:0] max_arena_reg;
    logic [bas_pkg::SIZE_W-1:0] max_alloc_reg;

    logic                       in_valid_reg;
    bas_pkg::req_t              in_req_reg;
    logic                       out_valid_reg;
    bas_pkg::rsp_t              out_rsp_reg;
    bas_pkg::rsp_t              out_rsp_next;

    logic [NUM_SLOTS-1:0]       live_reg;
    logic [NUM_SLOTS-1:0]       live_next;
    logic [bas_pkg::SIZE_W-1:0] cap_reg [ADDR_SLOTS];
    logic [bas_pkg::SIZE_W-1:0] off_reg [ADDR_SLOTS];

    logic                       advance;
    logic                       free_found;
    logic [SLOT_W-1:0]          free_idx;
    logic                       sel_live;
    logic [bas_pkg::SIZE_W-1:0] sel_cap;
    logic [bas_pkg::SIZE_W-1:0] sel_off;
    logic [bas_pkg::SIZE_W:0]   bump_sum;
    logic                       id_in_range;
    logic                       do_create;
    logic                       do_alloc;
    logic                       do_reset;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_arena_reg <= bas_pkg::MIN_ARENA_RST;
            max_arena_reg <= bas_pkg::MAX_ARENA_RST;
            max_alloc_reg <= bas_pkg::MAX_ALLOC_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == bas_pkg::CFG_MIN_ARENA) begin
                min_arena_reg <= cfg_wdata;
            end
            if (cfg_index == bas_pkg::CFG_MAX_ARENA) begin
                max_arena_reg <= cfg_wdata;
            end
            if (cfg_index == bas_pkg::CFG_MAX_ALLOC) begin
                max_alloc_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        sel_live = 1'b0;
        sel_cap  = '0;
        sel_off  = '0;
        for (int i = 0; i < ADDR_SLOTS; i++) begin
            if (bas_pkg::ID_W'(i) == in_req_reg.slot_id) begin
                sel_live = live_reg[i];
                sel_cap  = cap_reg[i];
                sel_off  = off_reg[i];
            end
        end
    end

    assign id_in_range = ({29'd0, in_req_reg.slot_id} < 32'(NUM_SLOTS));
    assign bump_sum    = {1'b0, sel_off} + {1'b0, in_req_reg.amount};

    always_comb begin
        out_rsp_next = '{ok: 1'b0, status: bas_pkg::ST_BAD_ID, value: '0};
        do_create    = 1'b0;
        do_alloc     = 1'b0;
        do_reset     = 1'b0;
        unique case (in_req_reg.req_type)
            bas_pkg::REQ_CREATE: begin
                if (in_req_reg.amount < min_arena_reg
                        || in_req_reg.amount > max_arena_reg) begin
                    out_rsp_next.status = bas_pkg::ST_BAD_SIZE;
                end else if (!free_found) begin
                    out_rsp_next.status = bas_pkg::ST_NO_SLOT;
                end else begin
                    do_create           = 1'b1;
                    out_rsp_next.ok     = 1'b1;
                    out_rsp_next.status = bas_pkg::ST_OK;
                    out_rsp_next.value  = bas_pkg::VALUE_W'(free_idx);
                end
            end
            bas_pkg::REQ_ALLOC, bas_pkg::REQ_RESET: begin
                priority if (!id_in_range || !sel_live) begin
                    out_rsp_next.status = bas_pkg::ST_BAD_ID;
                end else if (in_req_reg.req_type == bas_pkg::REQ_RESET) begin
                    do_reset            = 1'b1;
                    out_rsp_next.ok     = 1'b1;
                    out_rsp_next.status = bas_pkg::ST_OK;
                end else if (in_req_reg.amount == '0
                        || in_req_reg.amount > max_alloc_reg) begin
                    out_rsp_next.status = bas_pkg::ST_BAD_COUNT;
                end else if (bump_sum > {1'b0, sel_cap}) begin
                    out_rsp_next.status = bas_pkg::ST_FULL;
                end else begin
                    do_alloc            = 1'b1;
                    out_rsp_next.ok     = 1'b1;
                    out_rsp_next.status = bas_pkg::ST_OK;
                    out_rsp_next.value  = sel_off[bas_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                out_rsp_next.status = bas_pkg::ST_BAD_ID;
            end
        endcase
    end

    always_comb begin
        live_next = live_reg;
        if (advance && do_create) begin
            live_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_data;
        end
        if (advance) begin
            out_rsp_reg <= out_rsp_next;
        end
        for (int i = 0; i < ADDR_SLOTS; i++) begin
            if (advance && do_create && free_idx == SLOT_W'(i)) begin
                cap_reg[i] <= in_req_reg.amount;
                off_reg[i] <= '0;
            end else if (advance && in_req_reg.slot_id == bas_pkg::ID_W'(i)) begin
                if (do_reset) begin
                    off_reg[i] <= '0;
                end else if (do_alloc) begin
                    off_reg[i] <= bump_sum[bas_pkg::SIZE_W-1:0];
                end
            end
        end
    end

endmodule

// File: test/bump_arena_slot_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_arena_slot_allocator_test
// Self-checking bench for the arena slot allocator. Two short tables of
// requests cover empty slots, size and count limits, overflow,
// zero-size arenas and offsets beyond the result width. Random
// requests follow under four limit settings. Every response is compared
// with its pinned result or a cycle-free copy of the slot table, with
// random gaps on both handshakes and one long receiver stall.
// ----------------------------------------------------------------------------
module bump_arena_slot_allocator_test;

    localparam int unsigned NUM_SLOTS = 8;
    localparam int unsigned LONG_HOLD = 300;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [bas_pkg::CFG_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        bas_pkg::req_t req;
        logic          pinned;
        bas_pkg::rsp_t want;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    bas_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    bas_pkg::rsp_t m_data;
    logic cfg_wr_en;
    logic [bas_pkg::CFG_W-1:0] cfg_index;
    logic [bas_pkg::SIZE_W-1:0] cfg_wdata;

    logic pin_en;
    bas_pkg::rsp_t pin_rsp;

    bit arena_live [NUM_SLOTS];
    bit [bas_pkg::SIZE_W-1:0] arena_cap [NUM_SLOTS];
    bit [bas_pkg::SIZE_W-1:0] arena_off [NUM_SLOTS];
    logic [bas_pkg::SIZE_W-1:0] lim_min = bas_pkg::MIN_ARENA_RST;
    logic [bas_pkg::SIZE_W-1:0] lim_max = bas_pkg::MAX_ARENA_RST;
    logic [bas_pkg::SIZE_W-1:0] lim_alloc = bas_pkg::MAX_ALLOC_RST;

    bas_pkg::rsp_t owed [$];
    int unsigned requests_sent = 0;
    int unsigned responses_seen = 0;
    int unsigned outcome_count [8];
    int failures = 0;
    bit no_idle = 1'b0;
    bit hold_due = 1'b0;

    bump_arena_slot_allocator #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic bas_pkg::rsp_t arena_outcome(input bas_pkg::req_t r);
        bas_pkg::rsp_t o;
        logic [bas_pkg::SIZE_W:0] reach;
        logic placed;
        o.ok = 1'b0;
        o.status = bas_pkg::ST_OK;
        o.value = '0;
        placed = 1'b0;
        reach = {1'b0, arena_off[r.slot_id]} + {1'b0, r.amount};
        case (r.req_type)
            bas_pkg::REQ_CREATE: begin
                if (r.amount < lim_min || r.amount > lim_max) begin
                    o.status = bas_pkg::ST_BAD_SIZE;
                end else begin
                    o.status = bas_pkg::ST_NO_SLOT;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!placed && !arena_live[i]) begin
                            placed = 1'b1;
                            arena_live[i] = 1'b1;
                            arena_cap[i] = r.amount;
                            arena_off[i] = '0;
                            o.ok = 1'b1;
                            o.status = bas_pkg::ST_OK;
                            o.value = bas_pkg::VALUE_W'(i);
                        end
                    end
                end
            end
            bas_pkg::REQ_ALLOC, bas_pkg::REQ_RESET: begin
                if (!arena_live[r.slot_id]) begin
                    o.status = bas_pkg::ST_BAD_ID;
                end else if (r.req_type == bas_pkg::REQ_RESET) begin
                    arena_off[r.slot_id] = '0;
                    o.ok = 1'b1;
                end else if (r.amount == '0 || r.amount > lim_alloc) begin
                    o.status = bas_pkg::ST_BAD_COUNT;
                end else if (reach > {1'b0, arena_cap[r.slot_id]}) begin
                    o.status = bas_pkg::ST_FULL;
                end else begin
                    o.ok = 1'b1;
                    o.value = arena_off[r.slot_id][bas_pkg::VALUE_W-1:0];
                    arena_off[r.slot_id] = reach[bas_pkg::SIZE_W-1:0];
                end
            end
            default: o.status = bas_pkg::ST_BAD_ID;
        endcase
        return o;
    endfunction

    function automatic plan_row_t pinned_row(input logic [1:0] kind,
            input logic [bas_pkg::ID_W-1:0] id, input logic [bas_pkg::SIZE_W-1:0] amount,
            input logic ok, input bas_pkg::status_t status,
            input logic [bas_pkg::VALUE_W-1:0] value);
        plan_row_t p;
        p.req.req_type = kind;
        p.req.slot_id = id;
        p.req.amount = amount;
        p.pinned = 1'b1;
        p.want.ok = ok;
        p.want.status = status;
        p.want.value = value;
        return p;
    endfunction

    function automatic plan_row_t open_row(input logic [1:0] kind,
            input logic [bas_pkg::ID_W-1:0] id, input logic [bas_pkg::SIZE_W-1:0] amount);
        plan_row_t p;
        p = pinned_row(kind, id, amount, 1'b0, bas_pkg::ST_OK, '0);
        p.pinned = 1'b0;
        return p;
    endfunction

    function automatic plan_row_t random_request();
        int unsigned roll;
        logic [1:0] kind;
        logic [bas_pkg::SIZE_W-1:0] amount;
        roll = $urandom_range(0, 99);
        if (roll < 12) kind = bas_pkg::REQ_CREATE;
        else if (roll < 75) kind = bas_pkg::REQ_ALLOC;
        else if (roll < 94) kind = bas_pkg::REQ_RESET;
        else kind = REQ_UNKNOWN;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            amount = bas_pkg::SIZE_W'($urandom_range(1, 64));
        end else if (roll < 70) begin
            amount = bas_pkg::SIZE_W'($urandom_range(0, 4096));
        end else if (roll < 82) begin
            amount = bas_pkg::SIZE_W'($urandom);
        end else begin
            case ($urandom_range(0, 6))
                0: amount = lim_min - 1'b1;
                1: amount = lim_min;
                2: amount = lim_max;
                3: amount = lim_max + 1'b1;
                4: amount = lim_alloc;
                5: amount = lim_alloc + 1'b1;
                default: amount = '0;
            endcase
        end
        return open_row(kind, bas_pkg::ID_W'($urandom), amount);
    endfunction

    task automatic offer(input plan_row_t row);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= row.req;
        pin_en <= row.pinned;
        pin_rsp <= row.want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        requests_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (responses_seen != requests_sent) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [bas_pkg::SIZE_W-1:0] lo,
            input logic [bas_pkg::SIZE_W-1:0] hi, input logic [bas_pkg::SIZE_W-1:0] cap);
        logic [bas_pkg::CFG_W-1:0] index_list [4];
        logic [bas_pkg::SIZE_W-1:0] data_list [4];
        index_list[0] = bas_pkg::CFG_MIN_ARENA;
        index_list[1] = bas_pkg::CFG_MAX_ARENA;
        index_list[2] = bas_pkg::CFG_MAX_ALLOC;
        index_list[3] = CFG_SPARE;
        data_list[0] = lo;
        data_list[1] = hi;
        data_list[2] = cap;
        data_list[3] = bas_pkg::SIZE_W'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= index_list[i];
            cfg_wdata <= data_list[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [bas_pkg::SIZE_W-1:0] lo,
            input logic [bas_pkg::SIZE_W-1:0] hi, input logic [bas_pkg::SIZE_W-1:0] cap,
            input int unsigned count, input bit with_hold);
        drain();
        set_limits(lo, hi, cap);
        for (int n = 0; n < count; n++) begin
            no_idle = (n % 150) < 30;
            if (with_hold && n == 100) hold_due = 1'b1;
            offer(random_request());
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin : scoreboard
        bas_pkg::rsp_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bas_pkg::CFG_MIN_ARENA: lim_min = cfg_wdata;
                    bas_pkg::CFG_MAX_ARENA: lim_max = cfg_wdata;
                    bas_pkg::CFG_MAX_ALLOC: lim_alloc = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = arena_outcome(s_data);
                owed.push_back(pin_en ? pin_rsp : want);
            end
            if (m_valid && m_ready) begin
                if (owed.size() == 0) begin
                    $error("unexpected response ok=%0d status=%0d value=%0d",
                           m_data.ok, m_data.status, m_data.value);
                    failures++;
                end else begin
                    want = owed.pop_front();
                    outcome_count[want.status]++;
                    if (m_data.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, m_data.ok);
                        failures++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        failures++;
                    end
                    if (m_data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_data.value);
                        failures++;
                    end
                end
                responses_seen++;
            end
        end
    end

    initial begin : response_sink
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            // Hold off long enough for the request path to back up.
            if (hold_due) begin
                stall = LONG_HOLD;
                hold_due = 1'b0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        plan_row_t plan [$];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        pin_en <= 1'b0;
        pin_rsp <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd16,
                                  1'b0, bas_pkg::ST_BAD_ID, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_RESET, 3'd7, 29'd0,
                                  1'b0, bas_pkg::ST_BAD_ID, 28'd0));
        plan.push_back(pinned_row(REQ_UNKNOWN, 3'd5, 29'h1FFF_FFFF,
                                  1'b0, bas_pkg::ST_BAD_ID, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd0, 29'd63,
                                  1'b0, bas_pkg::ST_BAD_SIZE, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd2, 29'h1FFF_FFFF,
                                  1'b0, bas_pkg::ST_BAD_SIZE, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd0, 29'h1000_0001,
                                  1'b0, bas_pkg::ST_BAD_SIZE, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd6, 29'd64,
                                  1'b1, bas_pkg::ST_OK, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd0, 29'h1000_0000,
                                  1'b1, bas_pkg::ST_OK, 28'd1));
        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd0,
                                  1'b0, bas_pkg::ST_BAD_COUNT, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd1, 29'h400_0001,
                                  1'b0, bas_pkg::ST_BAD_COUNT, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd64,
                                  1'b1, bas_pkg::ST_OK, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd1,
                                  1'b0, bas_pkg::ST_FULL, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_RESET, 3'd0, 29'd9,
                                  1'b1, bas_pkg::ST_OK, 28'd0));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd40));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd0, 29'd24));
        repeat (4) plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd1, 29'h400_0000));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd1, 29'd1));
        foreach (plan[i]) offer(plan[i]);

        // Open the limits fully: zero-size arenas and offsets past the result width.
        drain();
        set_limits(29'd0, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
        plan.delete();
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd0, 29'd0,
                                  1'b1, bas_pkg::ST_OK, 28'd2));
        plan.push_back(pinned_row(bas_pkg::REQ_ALLOC, 3'd2, 29'd1,
                                  1'b0, bas_pkg::ST_FULL, 28'd0));
        plan.push_back(pinned_row(bas_pkg::REQ_CREATE, 3'd0, 29'h1FFF_FFFF,
                                  1'b1, bas_pkg::ST_OK, 28'd3));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd3, 29'h1000_0005));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd3, 29'd1));
        plan.push_back(open_row(bas_pkg::REQ_ALLOC, 3'd3, 29'h1FFF_FFFF));
        foreach (plan[i]) offer(plan[i]);

        random_phase(29'd16, 29'd8192, 29'd512, 600, 1'b1);
        random_phase(29'd1, 29'd1, 29'd1, 300, 1'b0);
        random_phase(29'h1000_0000, 29'h1000_0000, 29'h1000_0000, 300, 1'b0);
        random_phase(bas_pkg::MIN_ARENA_RST, bas_pkg::MAX_ARENA_RST,
                     bas_pkg::MAX_ALLOC_RST, 450, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (owed.size() != 0) begin
            $error("%0d responses still outstanding", owed.size());
            failures++;
        end
        $display("Covered %0d requests: directed slot cases, then four limit settings.",
                 requests_sent);
        $display("Outcomes: ok %0d, bad size %0d, no slot %0d, bad id %0d, bad count %0d, full %0d",
                 outcome_count[bas_pkg::ST_OK], outcome_count[bas_pkg::ST_BAD_SIZE],
                 outcome_count[bas_pkg::ST_NO_SLOT], outcome_count[bas_pkg::ST_BAD_ID],
                 outcome_count[bas_pkg::ST_BAD_COUNT], outcome_count[bas_pkg::ST_FULL]);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #800_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bas_pkg.sv
rtl/core/bump_arena_slot_allocator.sv
test/bump_arena_slot_allocator_test.sv
